// File: rtl/mlfq_pkg.sv
// Shared types, constants and the priority formula of the priority engine.
// No dependencies.
`default_nettype none
package mlfq_pkg;

    localparam int FP_SHIFT = 14;
    localparam logic [15:0] LOAD_KEEP = 16'd16110;
    localparam logic [15:0] LOAD_ADD = 16'd273;
    localparam logic [15:0] X100 = 16'd100;
    localparam logic [12:0] X100_MAX = 13'd8191;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_NICE   = 2'd1,
        OP_CREATE = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    localparam logic CFG_TIMER_FREQ = 1'b0;
    localparam logic CFG_HIGHEST = 1'b1;

    typedef struct packed {
        logic signed [31:0] rc;
        logic signed [5:0]  nice;
        logic [5:0]         prio;
    } slot_word_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T_RD, ST_T_INC, ST_L_MUL, ST_L_ADD, ST_X_MUL, ST_X_ST,
        ST_DIV_GO, ST_DIV_WAIT, ST_D_RD, ST_D_MUL, ST_D_WR,
        ST_P_RD, ST_P_CALC, ST_P_OUT, ST_E_RD, ST_E_LOAD,
        ST_N_RD, ST_N_WR, ST_C_RD, ST_C_WR, ST_R_DO, ST_OUT
    } state_t;

    // highest - recent/4 - 2*nice, rounded to nearest, clamped to 0..highest
    function automatic logic [5:0] prio_of(input logic signed [31:0] rc,
                                           input logic signed [5:0] nice,
                                           input logic [5:0] hp);
        logic signed [39:0] hp_fx;
        logic signed [39:0] q;
        logic signed [39:0] n_fx;
        logic signed [39:0] fx;
        logic signed [39:0] r;
        hp_fx = $signed({20'd0, hp, 14'd0});
        q = (rc < 0) ? (40'(rc) + 40'sd3) >>> 2 : 40'(rc) >>> 2;
        n_fx = 40'(nice) <<< 15;
        fx = hp_fx - q - n_fx;
        r = (fx + 40'sd8192) >>> FP_SHIFT;
        if (fx < 0)
            return 6'd0;
        else if (r > $signed({34'd0, hp}))
            return hp;
        else
            return r[5:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/mlfq_slot_ram.sv
// Slot table memory: one write port, one registered read port.
// Uses no package.
`default_nettype none
module mlfq_slot_ram #(
    parameter int DEPTH = 64,
    parameter int AW = 6,
    parameter int WIDTH = 44
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/mlfq_divider.sv
// Restoring divider, one quotient bit per cycle.
// Uses no package.
`default_nettype none
module mlfq_divider #(
    parameter int DW = 47,
    parameter int VW = 34
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic      [DW-1:0] quotient,
    output logic               done
);
    localparam int CW = $clog2(DW + 1);

    logic [VW:0]   rem_reg, rem_next;
    logic [DW-1:0] q_reg, q_next;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [VW:0]   shifted;

    always_comb
    begin
        shifted = {rem_reg[VW-1:0], q_reg[DW-1]};
        rem_next = rem_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next = '0;
            q_next = dividend;
            cnt_next = CW'(DW);
            done_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = shifted - {1'b0, dvs_reg};
                q_next = {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg <= q_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign quotient = q_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

// File: rtl/mlfq_priority_engine.sv
// Top level of the priority engine: sequencer, shared multiplier, slot table.
// Depends on mlfq_pkg, mlfq_slot_ram and mlfq_divider.
`default_nettype none
// Accepts one word at a time and stalls its input until every result of that
// word is taken. Set niceness, create, remove and a plain tick each give one
// result through the output handshake. A tick that ends a second also
// updates the load average, runs the 47-step divider and then walks the
// recent-CPU values of the valid slots through the single-port slot memory.
// Every fourth tick walks the slots again, with one result per valid slot.
// No clearing pass is needed after reset.
module mlfq_priority_engine
    import mlfq_pkg::*;
#(
    parameter int MAX_THREADS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [9:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        operation,
    input  wire logic [5:0]        slot,
    input  wire logic [5:0]        parent_slot,
    input  wire logic signed [5:0] nice_value,
    input  wire logic [5:0]        running_slot,
    input  wire logic              running_idle,
    input  wire logic [6:0]        ready_count,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [5:0]             out_slot,
    output logic [5:0]             out_priority,
    output logic [12:0]            load_avg_x100,
    output logic                   last_result
);
    localparam int IW = $clog2(MAX_THREADS);
    localparam int CNT_W = IW + 1;
    localparam int WW = $bits(slot_word_t);

    state_t state_reg, state_next;

    logic [9:0]  freq_reg;
    logic [5:0]  hp_reg;
    logic [1:0]  op_reg;
    logic [5:0]  slot_reg, ps_reg, rs_reg;
    logic signed [5:0] nv_reg;
    logic        idle_reg;
    logic [6:0]  ready_reg;
    logic [9:0]  phase_reg;
    logic [1:0]  qphase_reg;
    logic        quad_reg;
    logic [31:0] load_reg;
    logic [12:0] x100_reg;
    logic [14:0] frac_reg;
    logic signed [49:0] prod_reg;
    logic [CNT_W-1:0] i_reg;
    logic [MAX_THREADS-1:0] valid_reg;
    logic        ov_reg;
    logic [5:0]  os_reg, op_prio_reg;
    logic [12:0] ox_reg;
    logic        ol_reg;

    // memory port
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    slot_word_t    ram_wdata, rd_word;
    logic [WW-1:0] ram_rdata;

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [49:0] mul_p;

    logic        div_start, div_done;
    logic [46:0] div_q;

    function automatic logic [IW-1:0] idx6(input logic [5:0] x);
        logic [IW+5:0] e;
        e = {{IW{1'b0}}, x};
        return e[IW-1:0];
    endfunction

    function automatic logic in_range(input logic [5:0] x);
        return 32'(x) < MAX_THREADS;
    endfunction

    function automatic logic live(input logic [5:0] x);
        return in_range(x) && valid_reg[idx6(x)];
    endfunction

    assign rd_word = slot_word_t'(ram_rdata);

    logic [10:0] freq_eff;
    logic [10:0] phase_inc;
    logic        tick_sec, tick_quad;
    assign freq_eff = (freq_reg == '0) ? 11'd1 : {1'b0, freq_reg};
    assign phase_inc = {1'b0, phase_reg} + 11'd1;
    assign tick_sec = phase_inc >= freq_eff;
    assign tick_quad = (qphase_reg + 2'd1) == 2'd0;

    logic i_end, i_valid;
    logic [IW-1:0] i_idx;
    logic [MAX_THREADS-1:0] above;
    assign i_end = i_reg == CNT_W'(MAX_THREADS);
    assign i_idx = i_reg[IW-1:0];
    assign i_valid = !i_end && valid_reg[i_idx];

    for (genvar j = 0; j < MAX_THREADS; j++)
    begin : g_above
        assign above[j] = CNT_W'(j) > i_reg;
    end

    // arithmetic results
    logic [32:0] inc_sum;
    logic [31:0] rc_inc;
    assign inc_sum = 33'(rd_word.rc) + 33'd16384;
    assign rc_inc = ($signed(inc_sum) > 33'sh07fffffff) ? 32'h7fffffff : inc_sum[31:0];

    logic signed [49:0] dec_adj;
    logic signed [36:0] dec_sum;
    logic signed [31:0] rc_dec;
    always_comb
    begin
        dec_adj = (prod_reg < 0) ? prod_reg + 50'sd16383 : prod_reg;
        dec_sum = 37'(dec_adj >>> FP_SHIFT) + (37'(rd_word.nice) <<< FP_SHIFT);
        if (dec_sum > 37'sh007fffffff)
            rc_dec = 32'sh7fffffff;
        else if (dec_sum < -37'sh0080000000)
            rc_dec = 32'sh80000000;
        else
            rc_dec = dec_sum[31:0];
    end

    logic signed [50:0] x100_sum;
    assign x100_sum = 51'(prod_reg) + 51'sd8192;

    logic signed [5:0] nv_clamp;
    always_comb
    begin
        if (nv_reg < -6'sd20)
            nv_clamp = -6'sd20;
        else if (nv_reg > 6'sd20)
            nv_clamp = 6'sd20;
        else
            nv_clamp = nv_reg;
    end

    logic parent_live;
    logic signed [31:0] c_rc;
    logic signed [5:0]  c_nice;
    assign parent_live = live(ps_reg);
    assign c_rc = parent_live ? rd_word.rc : 32'sd0;
    assign c_nice = parent_live ? rd_word.nice : 6'sd0;

    logic [5:0] prio_nice, prio_create, prio_walk;
    assign prio_nice = prio_of(rd_word.rc, nv_clamp, hp_reg);
    assign prio_create = prio_of(c_rc, c_nice, hp_reg);
    assign prio_walk = prio_of(rd_word.rc, rd_word.nice, hp_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    case (op_t'(operation))
                        OP_TICK:   state_next = ST_T_RD;
                        OP_NICE:   state_next = ST_N_RD;
                        OP_CREATE: state_next = ST_C_RD;
                        default:   state_next = ST_R_DO;
                    endcase
                end
            ST_T_RD:  state_next = ST_T_INC;
            ST_T_INC:
                if (tick_sec)
                    state_next = ST_L_MUL;
                else if (tick_quad)
                    state_next = ST_P_RD;
                else
                    state_next = ST_E_RD;
            ST_L_MUL: state_next = ST_L_ADD;
            ST_L_ADD: state_next = ST_X_MUL;
            ST_X_MUL: state_next = ST_X_ST;
            ST_X_ST:  state_next = ST_DIV_GO;
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                    state_next = ST_D_RD;
            ST_D_RD:
                if (i_end)
                    state_next = quad_reg ? ST_P_RD : ST_E_RD;
                else if (i_valid)
                    state_next = ST_D_MUL;
            ST_D_MUL: state_next = ST_D_WR;
            ST_D_WR:  state_next = ST_D_RD;
            ST_P_RD:
                if (i_end)
                    state_next = ST_OUT;
                else if (i_valid)
                    state_next = ST_P_CALC;
            ST_P_CALC: state_next = ST_P_OUT;
            ST_P_OUT:
                if (!out_stall)
                    state_next = ol_reg ? ST_IDLE : ST_P_RD;
            ST_E_RD:   state_next = ST_E_LOAD;
            ST_E_LOAD: state_next = ST_OUT;
            ST_N_RD:   state_next = ST_N_WR;
            ST_N_WR:   state_next = ST_OUT;
            ST_C_RD:   state_next = ST_C_WR;
            ST_C_WR:   state_next = ST_OUT;
            ST_R_DO:   state_next = ST_OUT;
            ST_OUT:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall = state_reg != ST_IDLE;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_waddr = i_idx;
        ram_raddr = i_idx;
        ram_wdata = rd_word;
        div_start = 1'b0;
        mul_a = $signed({2'b00, load_reg});
        mul_b = $signed(LOAD_KEEP);
        case (state_reg)
            ST_T_RD:
            begin
                ram_re = 1'b1;
                ram_raddr = idx6(rs_reg);
            end
            ST_T_INC:
            begin
                ram_waddr = idx6(rs_reg);
                ram_wdata.rc = rc_inc;
                ram_we = !idle_reg && live(rs_reg);
            end
            ST_X_MUL: mul_b = $signed(X100);
            ST_DIV_GO: div_start = 1'b1;
            ST_D_RD: ram_re = i_valid;
            ST_D_MUL:
            begin
                mul_a = 34'(rd_word.rc);
                mul_b = $signed({1'b0, frac_reg});
            end
            ST_D_WR:
            begin
                ram_we = 1'b1;
                ram_wdata.rc = rc_dec;
            end
            ST_P_RD: ram_re = i_valid;
            ST_P_CALC:
            begin
                ram_we = 1'b1;
                ram_wdata.prio = prio_walk;
            end
            ST_E_RD:
            begin
                ram_re = 1'b1;
                ram_raddr = idx6(rs_reg);
            end
            ST_N_RD:
            begin
                ram_re = 1'b1;
                ram_raddr = idx6(slot_reg);
            end
            ST_N_WR:
            begin
                ram_waddr = idx6(slot_reg);
                ram_wdata.nice = nv_clamp;
                ram_wdata.prio = prio_nice;
                ram_we = live(slot_reg);
            end
            ST_C_RD:
            begin
                ram_re = 1'b1;
                ram_raddr = idx6(ps_reg);
            end
            ST_C_WR:
            begin
                ram_waddr = idx6(slot_reg);
                ram_wdata.rc = c_rc;
                ram_wdata.nice = c_nice;
                ram_wdata.prio = prio_create;
                ram_we = in_range(slot_reg);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign mul_p = 50'(mul_a) * 50'(mul_b);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            freq_reg <= 10'd100;
            hp_reg <= 6'd63;
            phase_reg <= '0;
            qphase_reg <= '0;
            load_reg <= '0;
            x100_reg <= '0;
            valid_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIMER_FREQ)
                    freq_reg <= cfg_data;
                else
                    hp_reg <= cfg_data[5:0];
            end
            case (state_reg)
                ST_T_INC:
                begin
                    phase_reg <= tick_sec ? 10'd0 : phase_inc[9:0];
                    qphase_reg <= qphase_reg + 2'd1;
                end
                ST_L_ADD:
                    load_reg <= prod_reg[45:14] + 32'(LOAD_ADD * 16'(ready_reg));
                ST_X_ST:
                    x100_reg <= (x100_sum >>> FP_SHIFT) > 51'(X100_MAX) ? X100_MAX
                                : x100_sum[26:14];
                ST_C_WR:
                    if (in_range(slot_reg))
                        valid_reg[idx6(slot_reg)] <= 1'b1;
                ST_R_DO:
                    if (live(slot_reg))
                        valid_reg[idx6(slot_reg)] <= 1'b0;
                default:
                begin
                end
            endcase
            if ((state_reg == ST_P_OUT || state_reg == ST_OUT) && !out_stall)
                ov_reg <= 1'b0;
            else if (state_next == ST_P_OUT || state_next == ST_OUT)
                ov_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                op_reg <= operation;
                slot_reg <= slot;
                ps_reg <= parent_slot;
                nv_reg <= nice_value;
                rs_reg <= running_slot;
                idle_reg <= running_idle;
                ready_reg <= ready_count;
                i_reg <= '0;
            end
            ST_T_INC: quad_reg <= tick_quad;
            ST_L_MUL, ST_X_MUL, ST_D_MUL: prod_reg <= mul_p;
            ST_DIV_WAIT: frac_reg <= div_q[14:0];
            ST_D_RD:
                if (i_end)
                    i_reg <= '0;
                else if (!i_valid)
                    i_reg <= i_reg + 1'b1;
            ST_D_WR: i_reg <= i_reg + 1'b1;
            ST_P_RD:
                if (i_end)
                begin
                    os_reg <= '0;
                    op_prio_reg <= '0;
                    ox_reg <= x100_reg;
                    ol_reg <= 1'b1;
                end
                else if (!i_valid)
                    i_reg <= i_reg + 1'b1;
            ST_P_CALC:
            begin
                os_reg <= 6'(i_reg);
                op_prio_reg <= prio_walk;
                ox_reg <= x100_reg;
                ol_reg <= ~|(valid_reg & above);
            end
            ST_P_OUT:
                if (!out_stall)
                    i_reg <= i_reg + 1'b1;
            ST_E_LOAD:
            begin
                os_reg <= rs_reg;
                op_prio_reg <= live(rs_reg) ? rd_word.prio : 6'd0;
                ox_reg <= x100_reg;
                ol_reg <= 1'b1;
            end
            ST_N_WR:
            begin
                os_reg <= slot_reg;
                op_prio_reg <= live(slot_reg) ? prio_nice : 6'd0;
                ox_reg <= x100_reg;
                ol_reg <= 1'b1;
            end
            ST_C_WR:
            begin
                os_reg <= slot_reg;
                op_prio_reg <= in_range(slot_reg) ? prio_create : 6'd0;
                ox_reg <= x100_reg;
                ol_reg <= 1'b1;
            end
            ST_R_DO:
            begin
                os_reg <= slot_reg;
                op_prio_reg <= 6'd0;
                ox_reg <= x100_reg;
                ol_reg <= op_reg == OP_REMOVE;
            end
            default:
            begin
            end
        endcase
    end

    mlfq_slot_ram #(
        .DEPTH (MAX_THREADS),
        .AW    (IW),
        .WIDTH (WW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // frac = 2L * 2^14 / (2L + 2^14)
    mlfq_divider #(
        .DW (47),
        .VW (34)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({load_reg, 15'd0}),
        .divisor  ({1'b0, load_reg, 1'b0} + 34'd16384),
        .quotient (div_q),
        .done     (div_done)
    );

    assign out_valid = ov_reg;
    assign out_slot = os_reg;
    assign out_priority = op_prio_reg;
    assign load_avg_x100 = ox_reg;
    assign last_result = ol_reg;
endmodule
`default_nettype wire

// File: rtl/mlfq_checker.sv
// Port-level checks of the priority engine, with the bind to the top level.
// Depends on mlfq_priority_engine ports only.
`default_nettype none
module mlfq_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [5:0] out_slot,
    input wire logic       last_result
);
    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_slot))
        else $error("stalled result word dropped or changed");

    // an accepted word keeps the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after accept");

    // no input is taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result waits");

    // more results follow a non-final one, so input stays stalled
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_result |=> in_stall)
        else $error("block went idle before the final result");
endmodule

bind mlfq_priority_engine mlfq_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_slot    (out_slot),
    .last_result (last_result)
);
`default_nettype wire

// File: tb/sv/tb_mlfq_priority_engine.sv
// Self-checking testbench of the priority engine: random and directed words,
// an in-bench predictor of the slot table, and a result scoreboard.
// Depends on mlfq_pkg and the mlfq_priority_engine RTL.
module tb_mlfq_priority_engine;
    import mlfq_pkg::*;

    typedef struct {
        logic [5:0]  slot_id;
        logic [5:0]  prio;
        logic [12:0] load_x100;
        logic        last;
    } prio_report_t;

    class mlfq_scoreboard;
        prio_report_t reports_q[$];
        int errors;
        longint recent[64];
        int nice_tab[64];
        int prio_tab[64];
        bit live_tab[64];
        longint load_fx;
        int sec_cnt;
        int quad_cnt;
        int freq_reg;
        int highest_reg;

        function new();
            errors = 0;
            load_fx = 0;
            sec_cnt = 0;
            quad_cnt = 0;
            freq_reg = 100;
            highest_reg = 63;
            for (int i = 0; i < 64; i++)
            begin
                recent[i] = 0;
                nice_tab[i] = 0;
                prio_tab[i] = 0;
                live_tab[i] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [9:0] data);
            if (idx == CFG_TIMER_FREQ)
                freq_reg = data;
            else
                highest_reg = data[5:0];
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function int calc_prio(longint rc, int nv);
            longint fx;
            longint r;
            fx = longint'(highest_reg) * 16384 - rc / 4 - longint'(nv) * 2 * 16384;
            if (fx >= 0)
                r = (fx + 8192) / 16384;
            else
                r = (fx - 8192) / 16384;
            if (r < 0)
                r = 0;
            if (r > highest_reg)
                r = highest_reg;
            return int'(r);
        endfunction

        function void push(int s, int p, bit last);
            prio_report_t r;
            longint x;
            x = (load_fx * 100 + 8192) / 16384;
            r.slot_id = s[5:0];
            r.prio = p[5:0];
            r.load_x100 = (x > 8191) ? 13'd8191 : x[12:0];
            r.last = last;
            reports_q.push_back(r);
        endfunction

        // called once per accepted input word
        function void note_word(logic [1:0] op, int s, int ps, logic signed [5:0] nv_in,
                                int rs, bit idle, int ready);
            int nv;
            int freq;
            bit sec;
            int n;
            longint two;
            longint frac;
            nv = nv_in;
            case (op_t'(op))
                OP_TICK:
                begin
                    freq = (freq_reg == 0) ? 1 : freq_reg;
                    if (!idle && live_tab[rs])
                        recent[rs] = sat32(recent[rs] + 16384);
                    sec_cnt++;
                    sec = sec_cnt >= freq;
                    if (sec)
                        sec_cnt = 0;
                    quad_cnt = (quad_cnt + 1) % 4;
                    if (sec)
                    begin
                        load_fx = (16110 * load_fx) / 16384 + 273 * longint'(ready);
                        two = 2 * load_fx;
                        frac = (two * 16384) / (two + 16384);
                        for (int i = 0; i < 64; i++)
                            if (live_tab[i])
                                recent[i] = sat32((frac * recent[i]) / 16384
                                                  + longint'(nice_tab[i]) * 16384);
                    end
                    if (quad_cnt == 0)
                    begin
                        n = 0;
                        for (int i = 0; i < 64; i++)
                            if (live_tab[i])
                            begin
                                prio_tab[i] = calc_prio(recent[i], nice_tab[i]);
                                push(i, prio_tab[i], 0);
                                n++;
                            end
                        if (n == 0)
                            push(0, 0, 1);
                        else
                            reports_q[$].last = 1;
                    end
                    else
                        push(rs, live_tab[rs] ? prio_tab[rs] : 0, 1);
                end
                OP_NICE:
                begin
                    if (live_tab[s])
                    begin
                        if (nv < -20)
                            nv = -20;
                        if (nv > 20)
                            nv = 20;
                        nice_tab[s] = nv;
                        prio_tab[s] = calc_prio(recent[s], nv);
                    end
                    push(s, live_tab[s] ? prio_tab[s] : 0, 1);
                end
                OP_CREATE:
                begin
                    nice_tab[s] = live_tab[ps] ? nice_tab[ps] : 0;
                    recent[s] = live_tab[ps] ? recent[ps] : 0;
                    prio_tab[s] = calc_prio(recent[s], nice_tab[s]);
                    live_tab[s] = 1;
                    push(s, prio_tab[s], 1);
                end
                default:
                begin
                    live_tab[s] = 0;
                    nice_tab[s] = 0;
                    recent[s] = 0;
                    prio_tab[s] = 0;
                    push(s, 0, 1);
                end
            endcase
        endfunction

        function void check_report(logic [5:0] s, logic [5:0] p, logic [12:0] l, logic last);
            prio_report_t e;
            if (reports_q.size() == 0)
            begin
                $error("unexpected result: out_slot %0d", s);
                errors++;
                return;
            end
            e = reports_q.pop_front();
            if (s !== e.slot_id)
            begin
                $error("out_slot expected %0d actual %0d", e.slot_id, s);
                errors++;
            end
            if (p !== e.prio)
            begin
                $error("out_priority expected %0d actual %0d", e.prio, p);
                errors++;
            end
            if (l !== e.load_x100)
            begin
                $error("load_avg_x100 expected %0d actual %0d", e.load_x100, l);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_result expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [9:0]        cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        operation;
    logic [5:0]        slot;
    logic [5:0]        parent_slot;
    logic signed [5:0] nice_value;
    logic [5:0]        running_slot;
    logic              running_idle;
    logic [6:0]        ready_count;
    logic              out_valid;
    logic              out_stall;
    logic [5:0]        out_slot;
    logic [5:0]        out_priority;
    logic [12:0]       load_avg_x100;
    logic              last_result;

    mlfq_scoreboard sb;
    int stall_pct;
    int hold_cycles;
    int gap_max;

    mlfq_priority_engine dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .slot(slot), .parent_slot(parent_slot),
        .nice_value(nice_value), .running_slot(running_slot),
        .running_idle(running_idle), .ready_count(ready_count),
        .out_valid(out_valid), .out_stall(out_stall), .out_slot(out_slot),
        .out_priority(out_priority), .load_avg_x100(load_avg_x100),
        .last_result(last_result)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        sb = new();
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_report(out_slot, out_priority, load_avg_x100, last_result);

    // receiver: random stall pattern, with an occasional long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else
                out_stall = ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_word(logic [1:0] op, int s, int ps, int nv, int rs, bit idle,
                             int ready);
        operation = op;
        slot = s[5:0];
        parent_slot = ps[5:0];
        nice_value = nv[5:0];
        running_slot = rs[5:0];
        running_idle = idle;
        ready_count = ready[6:0];
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(op, s, ps, nice_value, rs, idle, ready);
        @(negedge clk);
        // burst ends with a random gap
        if ($urandom_range(0, 3) == 0 && gap_max > 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.reports_q.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, int data);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data[9:0];
        sb.set_reg(idx, data[9:0]);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_words(int count);
        int op_pick;
        for (int k = 0; k < count; k++)
        begin
            if (k == count / 2)
                hold_cycles = 300;
            op_pick = $urandom_range(0, 99);
            send_word(op_pick < 45 ? OP_TICK : op_pick < 65 ? OP_CREATE :
                      op_pick < 82 ? OP_NICE : OP_REMOVE,
                      $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63) - 32, $urandom_range(0, 63),
                      $urandom_range(0, 4) == 0, $urandom_range(0, 64));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_TICK;
        slot = '0;
        parent_slot = '0;
        nice_value = '0;
        running_slot = '0;
        running_idle = 1'b0;
        ready_count = '0;
        stall_pct = 0;
        hold_cycles = 0;
        gap_max = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: absent parent, inherit, nice clamps, absent slots, idle ticks
        send_word(OP_CREATE, 0, 63, 0, 0, 0, 0);
        send_word(OP_CREATE, 63, 0, 0, 0, 0, 0);
        send_word(OP_NICE, 0, 0, -32, 0, 0, 0);
        send_word(OP_NICE, 63, 0, 31, 0, 0, 0);
        send_word(OP_NICE, 5, 0, 7, 0, 0, 0);
        send_word(OP_CREATE, 5, 63, 0, 0, 0, 0);
        send_word(OP_CREATE, 6, 0, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 0, 63, 0, 64);
        send_word(OP_TICK, 0, 0, 0, 0, 1, 0);
        send_word(OP_TICK, 0, 0, 0, 10, 0, 127);
        send_word(OP_TICK, 0, 0, 0, 0, 0, 64);
        send_word(OP_CREATE, 5, 5, 0, 0, 0, 0);
        send_word(OP_REMOVE, 5, 0, 0, 0, 0, 0);
        send_word(OP_REMOVE, 5, 0, 0, 0, 0, 0);
        send_word(OP_REMOVE, 63, 0, 0, 0, 0, 0);
        send_word(OP_REMOVE, 0, 0, 0, 0, 0, 0);
        send_word(OP_REMOVE, 6, 0, 0, 0, 0, 0);
        repeat (4) send_word(OP_TICK, 0, 0, 0, 0, 0, 0);

        write_reg(CFG_TIMER_FREQ, 1);
        write_reg(CFG_HIGHEST, 63);
        stall_pct = 30;
        gap_max = 4;
        random_words(100);

        write_reg(CFG_TIMER_FREQ, 1000);
        write_reg(CFG_HIGHEST, 1);
        stall_pct = 0;
        gap_max = 0;
        random_words(100);

        // sender waits for every result before going on
        drain();
        write_reg(CFG_TIMER_FREQ, 3);
        write_reg(CFG_HIGHEST, 20);
        stall_pct = 60;
        gap_max = 6;
        random_words(100);

        write_reg(CFG_TIMER_FREQ, 0);
        write_reg(CFG_HIGHEST, 40);
        stall_pct = 15;
        gap_max = 2;
        random_words(60);
        write_reg(CFG_TIMER_FREQ, 2);
        random_words(40);

        drain();
        if (sb.errors == 0 && sb.reports_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
